// File: rtl/kwrm_pkg.sv
// Package for the k-way run merger: word types, head status codes and sizes.
// Depends on nothing; every other file of the block imports it.
package kwrm_pkg;

	localparam int RUNS      = 8;
	localparam int RUN_BITS  = 3;
	localparam int WORD_BITS = 32;
	localparam int CNT_BITS  = 4;
	localparam int CFG_BITS  = 4;
	localparam int Q_DEPTH   = 2;

	localparam logic [CFG_BITS-1:0] RUNS_RESET = CFG_BITS'(RUNS);

	typedef enum logic [1:0] {
		HS_WAIT,
		HS_HOLD,
		HS_END
	} head_status_t;

	typedef struct packed {
		logic [RUN_BITS-1:0]         run_index;
		logic signed [WORD_BITS-1:0] head_value;
		logic                        run_ended;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0] merged_value;
		logic [RUN_BITS-1:0]         source_run;
		logic                        merge_done;
	} out_word_t;

	typedef struct packed {
		logic     in_range;
		in_word_t word;
	} queue_item_t;

	function automatic logic [CNT_BITS-1:0] runs_effective(input logic [CFG_BITS-1:0] v);
		logic [CNT_BITS-1:0] n;
		if (v == '0) begin
			n = CNT_BITS'(1);
		end else if (v > CFG_BITS'(RUNS)) begin
			n = CNT_BITS'(RUNS);
		end else begin
			n = CNT_BITS'(v);
		end
		return n;
	endfunction

endpackage

// File: rtl/kwrm_front.sv
// Front part of the merger: accepts input words, tags whether the run is in use,
// and holds them in a two-entry queue for the back part. Depends on kwrm_pkg.
module kwrm_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  kwrm_pkg::in_word_t            item,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  logic [kwrm_pkg::CNT_BITS-1:0] runs_eff,
	output kwrm_pkg::queue_item_t         q_head,
	output logic                          q_valid,
	input  logic                          q_pop
);
	import kwrm_pkg::*;

	queue_item_t entries_q [Q_DEPTH];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        push;
	logic        pop;
	queue_item_t incoming;

	assign item_ready = (count_q != 2'(Q_DEPTH));
	assign q_valid    = (count_q != 2'd0);
	assign q_head     = entries_q[rd_ptr_q];
	assign push       = item_valid && item_ready;
	assign pop        = q_pop && q_valid;

	always_comb begin
		incoming.word     = item;
		incoming.in_range = (CNT_BITS'(item.run_index) < runs_eff);
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: rtl/kwrm_back.sv
// Back part of the merger: run heads and status, the linear minimum scan and
// the result register. Holds the run count register. Depends on kwrm_pkg.
module kwrm_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kwrm_pkg::CFG_BITS-1:0] cfg_data,
	input  kwrm_pkg::queue_item_t         q_head,
	input  logic                          q_valid,
	output logic                          q_pop,
	output logic [kwrm_pkg::CNT_BITS-1:0] runs_eff,
	output logic                          result_valid,
	input  logic                          result_ready,
	output kwrm_pkg::out_word_t           result
);
	import kwrm_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	state_t                      state_q;
	logic [CFG_BITS-1:0]         runs_q;
	head_status_t                status_q [RUNS];
	logic signed [WORD_BITS-1:0] store_q [RUNS];
	logic [CNT_BITS-1:0]         active_q;
	logic [RUN_BITS-1:0]         scan_q;
	logic [RUN_BITS-1:0]         best_q;
	logic signed [WORD_BITS-1:0] best_val_q;
	logic                        best_found_q;
	logic                        emit_done_q;
	logic                        result_valid_q;
	out_word_t                   result_q;

	logic [CNT_BITS-1:0]         n;
	logic [RUN_BITS-1:0]         idx;
	logic                        take_item;
	logic                        waiting_other;
	logic [CNT_BITS-1:0]         active_next;
	logic signed [WORD_BITS-1:0] scan_val;
	logic                        cand_better;
	logic                        scan_last;
	logic                        emit_load;

	assign n            = runs_effective(runs_q);
	assign runs_eff     = n;
	assign cfg_ready    = 1'b1;
	assign q_pop        = (state_q == ST_IDLE) && q_valid;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign idx          = q_head.word.run_index;
	assign take_item    = q_head.in_range && (status_q[idx] == HS_WAIT);
	assign scan_val     = store_q[scan_q];
	assign scan_last    = (CNT_BITS'(scan_q) == (n - CNT_BITS'(1)));
	assign cand_better  = (status_q[scan_q] == HS_HOLD) && (!best_found_q || (scan_val < best_val_q));
	assign emit_load    = !cfg_valid && (state_q == ST_EMIT) && (!result_valid_q || result_ready);

	always_comb begin
		waiting_other = 1'b0;
		for (int i = 0; i < RUNS; i++) begin
			if ((CNT_BITS'(i) < n) && (RUN_BITS'(i) != idx) && (status_q[i] == HS_WAIT)) begin
				waiting_other = 1'b1;
			end
		end
		if (q_head.word.run_ended && (active_q != '0)) begin
			active_next = active_q - CNT_BITS'(1);
		end else begin
			active_next = active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (!cfg_valid && (state_q == ST_IDLE) && q_valid && take_item && !q_head.word.run_ended) begin
			store_q[idx] <= q_head.word.head_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			runs_q         <= RUNS_RESET;
			active_q       <= runs_effective(RUNS_RESET);
			result_valid_q <= 1'b0;
			scan_q         <= '0;
			best_q         <= '0;
			best_val_q     <= '0;
			best_found_q   <= 1'b0;
			emit_done_q    <= 1'b0;
			result_q       <= '0;
			for (int i = 0; i < RUNS; i++) begin
				status_q[i] <= HS_WAIT;
			end
		end else begin
			if (result_valid_q && result_ready && !emit_load) begin
				result_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				runs_q   <= cfg_data;
				active_q <= runs_effective(cfg_data);
				state_q  <= ST_IDLE;
				for (int i = 0; i < RUNS; i++) begin
					status_q[i] <= HS_WAIT;
				end
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (q_valid && take_item) begin
							if (!waiting_other && (active_next == '0)) begin
								emit_done_q <= 1'b1;
								active_q    <= n;
								state_q     <= ST_EMIT;
								for (int i = 0; i < RUNS; i++) begin
									status_q[i] <= HS_WAIT;
								end
							end else begin
								status_q[idx] <= q_head.word.run_ended ? HS_END : HS_HOLD;
								active_q      <= active_next;
								if (!waiting_other) begin
									scan_q       <= '0;
									best_found_q <= 1'b0;
									state_q      <= ST_SCAN;
								end
							end
						end
					end
					ST_SCAN: begin
						if (cand_better) begin
							best_q       <= scan_q;
							best_val_q   <= scan_val;
							best_found_q <= 1'b1;
						end
						if (scan_last) begin
							emit_done_q <= 1'b0;
							state_q     <= ST_EMIT;
						end else begin
							scan_q <= scan_q + RUN_BITS'(1);
						end
					end
					ST_EMIT: begin
						if (emit_load) begin
							result_valid_q <= 1'b1;
							if (emit_done_q) begin
								result_q <= '{merged_value: '0, source_run: '0, merge_done: 1'b1};
							end else begin
								result_q <= '{merged_value: best_val_q, source_run: best_q,
									merge_done: 1'b0};
								status_q[best_q] <= HS_WAIT;
							end
							state_q <= ST_IDLE;
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

endmodule

// File: rtl/k_way_run_merger.sv
// Top level of the k-way run merger: input queue front part and merge back part.
// Depends on kwrm_pkg, kwrm_front and kwrm_back.
//
//   channel   signals                              word
//   item      item_valid / item_ready / item       run_index, head_value, run_ended
//   result    result_valid / result_ready / result merged_value, source_run, merge_done
//   cfg       cfg_valid / cfg_ready / cfg_data     runs_in_use
//
// In the idle state the back part takes an item from the queue; an item that completes the set of heads
// starts the minimum scan over the runs in use, after which the emit state loads the result,
// so the scan over stored heads sets the cost of a merged value.
// Reset clears all run status to awaiting refill and the run count to eight.
// A two-word queue lets items arrive while a result waits to be taken.
module k_way_run_merger (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          item_valid,
	output logic                          item_ready,
	input  kwrm_pkg::in_word_t            item,
	output logic                          result_valid,
	input  logic                          result_ready,
	output kwrm_pkg::out_word_t           result,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [kwrm_pkg::CFG_BITS-1:0] cfg_data
);
	import kwrm_pkg::*;

	queue_item_t         q_head;
	logic                q_valid;
	logic                q_pop;
	logic [CNT_BITS-1:0] runs_eff;

	kwrm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.runs_eff   (runs_eff),
		.q_head     (q_head),
		.q_valid    (q_valid),
		.q_pop      (q_pop)
	);

	kwrm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.q_head       (q_head),
		.q_valid      (q_valid),
		.q_pop        (q_pop),
		.runs_eff     (runs_eff),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// File: rtl/kwrm_checker.sv
// Port checker for the k-way run merger, attached to the top level by bind.
// Depends on kwrm_pkg and k_way_run_merger.
module kwrm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          item_valid,
	input logic                          item_ready,
	input kwrm_pkg::in_word_t            item,
	input logic                          result_valid,
	input logic                          result_ready,
	input kwrm_pkg::out_word_t           result,
	input logic                          cfg_valid,
	input logic                          cfg_ready,
	input logic [kwrm_pkg::CFG_BITS-1:0] cfg_data
);
	import kwrm_pkg::*;

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.merge_done |-> (result.merged_value == '0) && (result.source_run == '0))
		else $error("completion word carries a value");

	a_queue_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> $past(item_valid && item_ready) || $past(!item_ready))
		else $error("item queue filled without an accepted word");

	a_cfg_open: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind k_way_run_merger kwrm_checker u_kwrm_checker (.*);
